>>> rtl/core/plt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Command and status codes shared by the positional list table.
// ----------------------------------------------------------------------------
package plt_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_APPEND = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;
	localparam cmd_t CMD_LOCATE = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

endpackage
`default_nettype wire

>>> rtl/core/positional_list_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_table_top
// Packed list of signed 32-bit entries with append, insert, delete, locate.
// ----------------------------------------------------------------------------
// Usage: one request on the in channel (cmd, index, item_value) gives one
// result on the out channel (status, removed_value, found, position, count).
// Entries live in a single RAM; one pointer adder and one equality compare
// walk it one entry per step (read, then write or compare).
// Append, or any refused request, answers straight from idle; insert walks
// down from the end shifting entries up, delete captures the removed entry
// and walks up shifting entries down, locate walks up from the front.
// The block takes one request at a time; in_ready is high only while idle
// and the output register is empty or being read in the same cycle, so a
// stalled result holds off the next request; a finished walk likewise holds
// until the output register frees up.
// Reset empties the list (count zero) and drops any pending result; the
// RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module positional_list_table_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire plt_pkg::cmd_t                cmd,
	input  wire logic [$clog2(DEPTH+1)-1:0]   index,
	input  wire logic signed [31:0]           item_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output plt_pkg::status_t                  status,
	output logic signed [31:0]                removed_value,
	output logic                              found,
	output logic [$clog2(DEPTH+1)-1:0]        position,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	import plt_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CAP  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_WR   = 2'd3;

	logic [1:0]       state_q, state_d;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] idx_q;
	logic [31:0]      val_q;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] ptr_q, ptr_d, ptr_nx;
	logic [31:0]      removed_q, removed_d;

	logic             out_valid_q;
	status_t          status_q;
	logic [31:0]      removed_out_q;
	logic             found_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;

	logic             slot_free;
	logic             accept;
	logic             done;
	status_t          r_status;
	logic [31:0]      r_removed;
	logic             r_found;
	logic [CNT_W-1:0] r_pos;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [31:0]       ram_rdata;

	plt_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	// shared pointer step: down for insert, up otherwise
	assign ptr_nx = CNT_W'(ptr_q + ((cmd_q == CMD_INSERT) ? {CNT_W{1'b1}} : CNT_W'(1)));

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		ptr_d     = ptr_q;
		removed_d = removed_q;
		done      = 1'b0;
		r_status  = ST_OK;
		r_removed = '0;
		r_found   = 1'b0;
		r_pos     = '0;
		ram_we    = 1'b0;
		ram_waddr = ptr_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_nx[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_APPEND: begin
							done = 1'b1;
							if (fill_q >= DEPTH_C) begin
								r_status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = fill_q[ADDR_W-1:0];
								ram_wdata = item_value;
								fill_d    = CNT_W'(fill_q + 1'b1);
							end
						end
						CMD_INSERT: begin
							if (index > fill_q) begin
								done     = 1'b1;
								r_status = ST_RANGE;
							end else if (fill_q >= DEPTH_C) begin
								done     = 1'b1;
								r_status = ST_FULL;
							end else begin
								ptr_d   = fill_q;
								state_d = S_RD;
							end
						end
						CMD_DELETE: begin
							if (index >= fill_q) begin
								done     = 1'b1;
								r_status = ST_RANGE;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = index[ADDR_W-1:0];
								ptr_d     = index;
								state_d   = S_CAP;
							end
						end
						CMD_LOCATE: begin
							ptr_d   = '0;
							state_d = S_RD;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_CAP: begin
				removed_d = ram_rdata;
				state_d   = S_RD;
			end
			S_RD: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (ptr_q == idx_q) begin
							if (slot_free) begin
								ram_we    = 1'b1;
								ram_wdata = val_q;
								fill_d    = CNT_W'(fill_q + 1'b1);
								done      = 1'b1;
								state_d   = S_IDLE;
							end
						end else begin
							ram_re  = 1'b1;
							state_d = S_WR;
						end
					end
					CMD_DELETE: begin
						if (ptr_nx < fill_q) begin
							ram_re  = 1'b1;
							state_d = S_WR;
						end else if (slot_free) begin
							fill_d    = CNT_W'(fill_q - 1'b1);
							r_removed = removed_q;
							done      = 1'b1;
							state_d   = S_IDLE;
						end
					end
					CMD_LOCATE: begin
						if (ptr_q < fill_q) begin
							ram_re    = 1'b1;
							ram_raddr = ptr_q[ADDR_W-1:0];
							state_d   = S_WR;
						end else if (slot_free) begin
							done    = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_WR: begin
				case (cmd_q) inside
					CMD_INSERT, CMD_DELETE: begin
						ram_we  = 1'b1;
						ptr_d   = ptr_nx;
						state_d = S_RD;
					end
					CMD_LOCATE: begin
						if (ram_rdata == val_q) begin
							if (slot_free) begin
								r_found = 1'b1;
								r_pos   = ptr_nx;
								done    = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							ptr_d   = ptr_nx;
							state_d = S_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		removed_q <= removed_d;
		if (accept) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= item_value;
		end
		if (done) begin
			status_q      <= r_status;
			removed_out_q <= r_removed;
			found_q       <= r_found;
			pos_q         <= r_pos;
			count_q       <= fill_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_out_q;
	assign found         = found_q;
	assign position      = pos_q;
	assign count         = count_q;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("request taken outside idle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_APPEND) && (fill_q < DEPTH_C))
		|=> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
		else $error("append did not grow the list");

	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> ((position != '0) && (position <= count)))
		else $error("found position out of list");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> ((removed_value == '0) && !found))
		else $error("refused request carries data");
`endif

endmodule
`default_nettype wire

>>> rtl/core/plt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module plt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> tb/positional_list_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_table_top_tb
// Self-checking bench for the positional list table.
// A driver pushes requests from a queue in bursts with random gaps, and a
// monitor takes results under a changing stall pattern. Each accepted request
// runs through a local copy of the list that predicts status, removed value,
// locate result and count. Every result is compared field by field in order.
// ----------------------------------------------------------------------------
module positional_list_table_top_tb;

	import plt_pkg::*;

	localparam int DEPTH        = 16;
	localparam int IW           = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

	typedef struct {
		cmd_t                cmd;
		logic [IW-1:0]       index;
		logic signed [31:0]  value;
	} list_req_t;

	typedef struct {
		status_t             status;
		logic signed [31:0]  removed;
		logic                found;
		logic [IW-1:0]       position;
		logic [IW-1:0]       count;
	} list_result_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	cmd_t                cmd           = CMD_APPEND;
	logic [IW-1:0]       index         = '0;
	logic signed [31:0]  item_value    = '0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	status_t             status;
	logic signed [31:0]  removed_value;
	logic                found;
	logic [IW-1:0]       position;
	logic [IW-1:0]       count;

	positional_list_table_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.index        (index),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.removed_value(removed_value),
		.found        (found),
		.position     (position),
		.count        (count)
	);

	list_req_t           pending_reqs[$];
	list_result_t        expected_results[$];
	logic signed [31:0]  list_mem[DEPTH];
	int                  list_fill = 0;
	int                  gen_fill  = 0;
	logic signed [31:0]  value_pool[8];
	int                  error_count = 0;
	int                  cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// list behavior, applied to the local copy
	function automatic list_result_t apply_list_cmd(cmd_t op, logic [IW-1:0] idx,
			logic signed [31:0] val);
		list_result_t r;
		int j;
		r.status   = ST_OK;
		r.removed  = '0;
		r.found    = 1'b0;
		r.position = '0;
		case (op)
			CMD_APPEND: begin
				if (list_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_mem[list_fill] = val;
					list_fill++;
				end
			end
			CMD_INSERT: begin
				if (int'(idx) > list_fill) begin
					r.status = ST_RANGE;
				end else if (list_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (j = list_fill; j > int'(idx); j--)
						list_mem[j] = list_mem[j-1];
					list_mem[idx] = val;
					list_fill++;
				end
			end
			CMD_DELETE: begin
				if (int'(idx) >= list_fill) begin
					r.status = ST_RANGE;
				end else begin
					r.removed = list_mem[idx];
					for (j = int'(idx); j + 1 < list_fill; j++)
						list_mem[j] = list_mem[j+1];
					list_fill--;
				end
			end
			default: begin
				for (j = 0; j < list_fill; j++) begin
					if (!r.found && list_mem[j] == val) begin
						r.found    = 1'b1;
						r.position = IW'(j + 1);
					end
				end
			end
		endcase
		r.count = IW'(list_fill);
		return r;
	endfunction

	// queue a request and track the fill level it leads to
	task automatic add_req(cmd_t op, int idx, logic signed [31:0] val);
		list_req_t req;
		req.cmd   = op;
		req.index = IW'(idx);
		req.value = val;
		pending_reqs.insert(pending_reqs.size(), req);
		case (op)
			CMD_APPEND: if (gen_fill < DEPTH) gen_fill++;
			CMD_INSERT: if (int'(req.index) <= gen_fill && gen_fill < DEPTH) gen_fill++;
			CMD_DELETE: if (int'(req.index) < gen_fill) gen_fill--;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string field, longint exp_v, longint act_v);
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
		error_count++;
	endtask

	// driver
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_proc
		list_req_t req;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					apply_list_cmd(cmd, index, item_value));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req = pending_reqs.pop_front();
					cmd        <= req.cmd;
					index      <= req.index;
					item_value <= req.value;
					in_valid   <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_mode = 0;
	int phase_left = 0;

	always @(posedge clk) begin : monitor_proc
		list_result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request pending, status %0d count %0d",
						$time, status, count);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status)
						report_mismatch("status", exp_r.status, status);
					if (removed_value !== exp_r.removed)
						report_mismatch("removed_value", exp_r.removed, removed_value);
					if (found !== exp_r.found)
						report_mismatch("found", exp_r.found, found);
					if (position !== exp_r.position)
						report_mismatch("position", exp_r.position, position);
					if (count !== exp_r.count)
						report_mismatch("count", exp_r.count, count);
				end
			end
			if (phase_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				phase_left <= $urandom_range(10, 150);
			end else begin
				phase_left <= phase_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stim_proc
		int n;
		int op_roll;
		int idx;
		bit draining;
		cmd_t op;
		logic signed [31:0] val;

		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7FFF_FFFF;
		value_pool[2] = 32'sh0000_0000;
		value_pool[3] = -32'sd1;
		for (n = 4; n < 8; n++)
			value_pool[n] = $urandom;

		// empty list cases
		add_req(CMD_LOCATE, 0, 32'sd5);
		add_req(CMD_DELETE, 0, 32'sd0);
		add_req(CMD_INSERT, 1, 32'sd7);
		// extremes, insert at front and at count
		add_req(CMD_APPEND, 0, 32'sh8000_0000);
		add_req(CMD_APPEND, 31, 32'sh7FFF_FFFF);
		add_req(CMD_INSERT, 0, -32'sd1);
		add_req(CMD_INSERT, 3, 32'sd0);
		add_req(CMD_LOCATE, 0, 32'sh7FFF_FFFF);
		add_req(CMD_LOCATE, 0, 32'sd12345);
		add_req(CMD_DELETE, 4, 32'sd0);
		// fill to the top
		for (n = 0; n < DEPTH - 4; n++)
			add_req(CMD_APPEND, 0, (n % 2) ? -32'sd1 : 32'(n));
		add_req(CMD_APPEND, 0, 32'sd99);
		add_req(CMD_INSERT, 2, 32'sd99);
		add_req(CMD_INSERT, 17, 32'sd99);
		add_req(CMD_DELETE, DEPTH - 1, 32'sd0);
		add_req(CMD_DELETE, 0, 32'sd0);

		draining = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (gen_fill == DEPTH && $urandom_range(0, 3) == 0)
				draining = 1'b1;
			else if (gen_fill == 0)
				draining = 1'b0;
			else if ($urandom_range(0, 63) == 0)
				draining = ~draining;
			op_roll = $urandom_range(0, 99);
			if (!draining)
				op = (op_roll < 30) ? CMD_APPEND : (op_roll < 60) ? CMD_INSERT :
					(op_roll < 75) ? CMD_DELETE : CMD_LOCATE;
			else
				op = (op_roll < 10) ? CMD_APPEND : (op_roll < 20) ? CMD_INSERT :
					(op_roll < 75) ? CMD_DELETE : CMD_LOCATE;
			idx = $urandom_range(0, 31);
			if (op == CMD_INSERT && $urandom_range(0, 99) < 85)
				idx = $urandom_range(0, gen_fill);
			else if (op == CMD_DELETE && gen_fill > 0 && $urandom_range(0, 99) < 85)
				idx = $urandom_range(0, gen_fill - 1);
			val = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
			add_req(op, idx, val);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
